### rtl/pswb_pkg.sv
// pswb_pkg: shared types and codes of the priority send window buffer
// no dependencies
`default_nettype none

package pswb_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_SEND      = 3'd1,
    REQ_ACK       = 3'd2,
    REQ_TICK      = 3'd3,
    REQ_RECONNECT = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOSEND  = 2'd2,
    STAT_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_BUFFER_LIMIT = 2'd0,
    CFG_WINDOW_K     = 2'd1,
    CFG_ACK_TIMEOUT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EX,
    ST_SCAN_RD,
    ST_SCAN_EX,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  len;
    logic [7:0]  prio;
    logic [14:0] seq;
    logic        sent;
    logic [7:0]  age;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [6:0] buffer_limit;
    logic [6:0] window_k;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic        send_valid;
    logic [15:0] send_tag;
    logic [7:0]  send_length;
    logic [14:0] send_sequence;
    logic [6:0]  removed_count;
    logic [6:0]  held_count;
    logic [6:0]  unacked_count;
  } res_t;

endpackage

`default_nettype wire

### rtl/pswb_ram.sv
// pswb_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pswb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/pswb_ctrl.sv
// pswb_ctrl: sequencer walking the entry ram one slot at a time
// depends on pswb_pkg
`default_nettype none

module pswb_ctrl import pswb_pkg::*; #(
  parameter int unsigned MaxEntries = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  priority_req_i,
  input  wire logic [15:0] payload_tag_i,
  input  wire logic [7:0]  payload_length_i,
  input  wire logic [14:0] ack_number_i,
  input  wire cfg_t        cfg_i,
  output logic             busy_o,
  output logic             done_o,
  output res_t             res_o,
  // entry ram
  output logic                          ram_we_o,
  output logic [$clog2(MaxEntries)-1:0] ram_waddr_o,
  output entry_t                        ram_wdata_o,
  output logic [$clog2(MaxEntries)-1:0] ram_raddr_o,
  input  wire entry_t                   ram_rdata_i
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  state_e             state_q, state_d;
  req_e               op_q, op_d;
  entry_t             new_q, new_d;
  logic [14:0]        ackn_q, ackn_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    unacked_q, unacked_d;
  logic [14:0]        ctr_q, ctr_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    kept_q, kept_d;
  logic [CntW-1:0]    removed_q, removed_d;
  status_e            status_q, status_d;
  logic               sv_q, sv_d;
  logic [15:0]        stag_q, stag_d;
  logic [7:0]         slen_q, slen_d;
  logic [14:0]        sseq_q, sseq_d;
  logic               done_q, done_d;
  res_t               res_q, res_d;
  logic [14:0]        ctr_inc;
  entry_t             wr_entry;

  assign ctr_inc = ctr_q + 15'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      unacked_q <= '0;
      ctr_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      unacked_q <= unacked_d;
      ctr_q     <= ctr_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    new_q     <= new_d;
    ackn_q    <= ackn_d;
    idx_q     <= idx_d;
    kept_q    <= kept_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    sv_q      <= sv_d;
    stag_q    <= stag_d;
    slen_q    <= slen_d;
    sseq_q    <= sseq_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    new_d       = new_q;
    ackn_d      = ackn_q;
    count_d     = count_q;
    unacked_d   = unacked_q;
    ctr_d       = ctr_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    removed_d   = removed_q;
    status_d    = status_q;
    sv_d        = sv_q;
    stag_d      = stag_q;
    slen_d      = slen_q;
    sseq_d      = sseq_q;
    done_d      = 1'b0;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q[IdxW-1:0];
    ram_wdata_o = new_q;
    ram_raddr_o = idx_q[IdxW-1:0];
    wr_entry    = ram_rdata_i;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d      = req_e'(req_type_i);
          new_d     = '{tag: payload_tag_i, len: payload_length_i, prio: priority_req_i,
                        seq: '0, sent: 1'b0, age: '0};
          ackn_d    = ack_number_i;
          idx_d     = '0;
          kept_d    = '0;
          removed_d = '0;
          status_d  = STAT_OK;
          sv_d      = 1'b0;
          stag_d    = '0;
          slen_d    = '0;
          sseq_d    = '0;
          state_d   = ST_SCAN_RD;
          case (req_e'(req_type_i))
            REQ_INSERT: begin
              if (CmpW'(count_q) >= CmpW'(cfg_i.buffer_limit) ||
                  CmpW'(count_q) >= CmpW'(MaxEntries)) begin
                status_d = STAT_FULL;
                state_d  = ST_RESP;
              end else begin
                idx_d   = count_q;
                state_d = ST_INS_RD;
              end
            end
            REQ_SEND: begin
              if (CmpW'(unacked_q) >= CmpW'(cfg_i.window_k)) begin
                status_d = STAT_NOSEND;
                state_d  = ST_RESP;
              end
            end
            REQ_ACK, REQ_TICK: ;
            REQ_RECONNECT: begin
              ctr_d     = '0;
              unacked_d = '0;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      // walk down from the tail, shifting lower-priority entries up one slot
      ST_INS_RD: begin
        if (idx_q == '0) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = '0;
          count_d     = count_q + 1'b1;
          state_d     = ST_RESP;
        end else begin
          ram_raddr_o = IdxW'(idx_q - 1'b1);
          state_d     = ST_INS_EX;
        end
      end

      ST_INS_EX: begin
        ram_we_o = 1'b1;
        if (new_q.prio < ram_rdata_i.prio) begin
          ram_wdata_o = ram_rdata_i;
          idx_d       = idx_q - 1'b1;
          state_d     = ST_INS_RD;
        end else begin
          count_d = count_q + 1'b1;
          state_d = ST_RESP;
        end
      end

      ST_SCAN_RD: begin
        if (idx_q == count_q) begin
          if (op_q == REQ_SEND) begin
            status_d = STAT_NOSEND;
          end else if (op_q == REQ_ACK) begin
            count_d   = kept_q;
            unacked_d = (unacked_q >= removed_q) ? unacked_q - removed_q : '0;
          end
          state_d = ST_RESP;
        end else begin
          state_d = ST_SCAN_EX;
        end
      end

      ST_SCAN_EX: begin
        idx_d   = idx_q + 1'b1;
        state_d = ST_SCAN_RD;
        case (op_q)
          REQ_SEND: begin
            if (!ram_rdata_i.sent) begin
              wr_entry.seq  = ctr_inc;
              wr_entry.sent = 1'b1;
              wr_entry.age  = '0;
              ram_we_o      = 1'b1;
              ram_wdata_o   = wr_entry;
              sv_d          = 1'b1;
              stag_d        = ram_rdata_i.tag;
              slen_d        = ram_rdata_i.len;
              sseq_d        = ctr_q;
              ctr_d         = ctr_inc;
              unacked_d     = unacked_q + 1'b1;
              state_d       = ST_RESP;
            end
          end
          REQ_ACK: begin
            if (ram_rdata_i.sent && ram_rdata_i.seq <= ackn_q) begin
              removed_d = removed_q + 1'b1;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = kept_q[IdxW-1:0];
              ram_wdata_o = ram_rdata_i;
              kept_d      = kept_q + 1'b1;
            end
          end
          REQ_TICK: begin
            if (ram_rdata_i.sent) begin
              ram_we_o = 1'b1;
              if (ram_rdata_i.age < cfg_i.ack_timeout) begin
                wr_entry.age = ram_rdata_i.age + 8'd1;
              end else begin
                wr_entry.age = '0;
                status_d     = STAT_TIMEOUT;
                state_d      = ST_RESP;
              end
              ram_wdata_o = wr_entry;
            end
          end
          REQ_RECONNECT: begin
            wr_entry.sent = 1'b0;
            wr_entry.age  = '0;
            ram_we_o      = 1'b1;
            ram_wdata_o   = wr_entry;
          end
          default: state_d = ST_RESP;
        endcase
      end

      ST_RESP: begin
        done_d = 1'b1;
        res_d  = '{status: status_q, send_valid: sv_q, send_tag: stag_q,
                   send_length: slen_q, send_sequence: sseq_q,
                   removed_count: 7'(CmpW'(removed_q)),
                   held_count: 7'(CmpW'(count_q)),
                   unacked_count: 7'(CmpW'(unacked_q))};
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // every unacknowledged entry is still held
  a_unacked_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unacked_q <= count_q) else $error("unacked count exceeds held count");

  a_count_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(MaxEntries)) else $error("held count beyond capacity");

  a_done_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == ST_RESP) else $error("result without response state");

  a_send_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.send_valid) |-> res_q.status == STAT_OK)
    else $error("send reported with bad status");

endmodule

`default_nettype wire

### rtl/priority_send_window_buffer.sv
// priority_send_window_buffer: top level, configuration registers and entry ram
// depends on pswb_pkg, pswb_ram, pswb_ctrl
`default_nettype none

// Send buffer of frame descriptors kept in priority order in a single-port-write ram.
// A request is taken when start_i is high and busy_o is low; its one result shows on
// the result ports for exactly one cycle with done_o high and cannot be held off, so
// the receiver must take it then. Every request is carried out by a sequencer that
// visits one ram slot at a time, first presenting its address, then using the registered
// read data, so the cost of a request is set by the number of held entries n: an insert
// walks from the tail down to its landing slot, send, acknowledge, tick and reconnect
// walk at most all n slots, and a full or closed-window refusal and an unknown request
// walk no slot at all. busy_o stays high for the whole walk. No clearing pass
// follows reset: slots are only read below the fill count and each is written by an
// insert first. Configuration writes take effect at once and belong to idle periods.

module priority_send_window_buffer import pswb_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // request
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  priority_req_i,
  input  wire logic [15:0] payload_tag_i,
  input  wire logic [7:0]  payload_length_i,
  input  wire logic [14:0] ack_number_i,
  // result
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             send_valid_o,
  output logic [15:0]      send_tag_o,
  output logic [7:0]       send_length_o,
  output logic [14:0]      send_sequence_o,
  output logic [6:0]       removed_count_o,
  output logic [6:0]       held_count_o,
  output logic [6:0]       unacked_count_o
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);

  cfg_t              cfg_q;
  res_t              res;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [IdxW-1:0]   ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [EntryW-1:0] ram_rdata_raw;

  // configuration registers, reset to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_limit <= 7'd32;
      cfg_q.window_k     <= 7'd12;
      cfg_q.ack_timeout  <= 8'd15;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BUFFER_LIMIT: cfg_q.buffer_limit <= cfg_wdata_i[6:0];
        CFG_WINDOW_K:     cfg_q.window_k     <= cfg_wdata_i[6:0];
        CFG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_wdata_i;
        default: ;  // unused index, transfer ignored
      endcase
    end
  end

  // entry descriptors, one record per slot
  pswb_ram #(
    .Width (EntryW),
    .Depth (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // sequencer: one slot compare and rewrite per visit
  pswb_ctrl #(
    .MaxEntries (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .req_type_i       (req_type_i),
    .priority_req_i   (priority_req_i),
    .payload_tag_i    (payload_tag_i),
    .payload_length_i (payload_length_i),
    .ack_number_i     (ack_number_i),
    .cfg_i            (cfg_q),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .res_o            (res),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata)
  );

  // result fields straight from the sequencer's output register
  assign status_o        = res.status;
  assign send_valid_o    = res.send_valid;
  assign send_tag_o      = res.send_tag;
  assign send_length_o   = res.send_length;
  assign send_sequence_o = res.send_sequence;
  assign removed_count_o = res.removed_count;
  assign held_count_o    = res.held_count;
  assign unacked_count_o = res.unacked_count;

endmodule

`default_nettype wire
